// File: design/iiee_pkg.sv
// Shared types and constants of the infix integer expression evaluator.
package iiee_pkg;

  localparam int unsigned PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  // Operator that follows an operand.
  localparam logic [2:0] FUNC_PLUS   = 3'd0;
  localparam logic [2:0] FUNC_MINUS  = 3'd1;
  localparam logic [2:0] FUNC_TIMES  = 3'd2;
  localparam logic [2:0] FUNC_DIVIDE = 3'd3;
  localparam logic [2:0] FUNC_EQUALS = 3'd4;

  // Pending multiplicative operator.
  localparam logic [1:0] MOP_NONE   = 2'd0;
  localparam logic [1:0] MOP_TIMES  = 2'd1;
  localparam logic [1:0] MOP_DIVIDE = 2'd2;

  // Program addresses.
  localparam pc_t PC_FETCH    = 4'd0;
  localparam pc_t PC_SEL_NONE = 4'd1;
  localparam pc_t PC_SEL_MUL  = 4'd2;
  localparam pc_t PC_DIV_INIT = 4'd3;
  localparam pc_t PC_DIV_STEP = 4'd4;
  localparam pc_t PC_DIV_FIN  = 4'd5;
  localparam pc_t PC_DIV_ZERO = 4'd6;
  localparam pc_t PC_TERM_X   = 4'd7;
  localparam pc_t PC_MUL_LL   = 4'd8;
  localparam pc_t PC_MUL_LH   = 4'd9;
  localparam pc_t PC_MUL_HL   = 4'd10;
  localparam pc_t PC_MUL_ACC  = 4'd11;
  localparam pc_t PC_MULOP    = 4'd12;
  localparam pc_t PC_ADD      = 4'd13;
  localparam pc_t PC_EMIT     = 4'd14;

  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_FETCH,
    UOP_DIV_INIT,
    UOP_DIV_STEP,
    UOP_DIV_FIN,
    UOP_TERM_ZERO,
    UOP_TERM_X,
    UOP_MUL_LL,
    UOP_MUL_LH,
    UOP_MUL_HL,
    UOP_MUL_ACC,
    UOP_MULOP,
    UOP_ADD,
    UOP_EMIT
  } uop_e;

  typedef enum logic [3:0] {
    COND_ALWAYS,
    COND_NO_TOKEN,
    COND_MOP_NONE,
    COND_MOP_TIMES,
    COND_DIV_ZERO,
    COND_DIV_MORE,
    COND_FUNC_MUL,
    COND_FUNC_NOT_EQ,
    COND_OUT_BUSY
  } cond_e;

  // One control word: datapath operation, jump condition and target,
  // and whether falling through returns to the fetch step.
  typedef struct packed {
    uop_e  uop;
    cond_e cond;
    pc_t   target;
    logic  last;
  } ucw_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic mop_none;
    logic mop_times;
    logic x_zero;
    logic div_more;
    logic func_mul;
    logic func_not_eq;
    logic out_busy;
  } stat_t;

endpackage

// File: design/iiee_in_if.sv
// Token channel: operand and following operator with valid/ready.
interface iiee_in_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] operand;
  logic        [2:0]  func;

  modport source (output valid, output operand, output func, input ready);
  modport sink (input valid, input operand, input func, output ready);
endinterface

// File: design/iiee_out_if.sv
// Result channel: expression value and divide-by-zero flag with valid/ready.
interface iiee_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic               div_by_zero;

  modport source (output valid, output value, output div_by_zero, input ready);
  modport sink (input valid, input value, input div_by_zero, output ready);
endinterface

// File: design/infix_integer_expression_evaluator_core.sv
// Top level of the infix integer expression evaluator: sequencer and wiring.
//
// Usage: tokens enter on in_tok_i, one signed 64-bit operand plus the operator
// that follows it (plus, minus, times, divide, equals). '*' and '/' bind
// tighter than '+' and '-', both left to right. An equals token makes one
// transaction on res_o carrying the wrapped value and a flag that is set if
// any divisor in the expression was zero; the expression state then clears.
// Tokens with an unknown operator are taken and dropped.
//
// Sequencing: a microcoded sequencer steps through a 15-word control store.
// A token goes through fetch and select, then forms the term: the operand if
// no product is pending, the MUL_LL, MUL_LH, MUL_HL and MUL_ACC steps after a
// pending '*', zero after a pending '/' by zero, else the one-bit-per-cycle
// divide loop; '+' or '-' adds the add step and equals adds add and emit.
// in_tok_i.ready is high only in the fetch step. The result waits in an output
// register; the block keeps taking tokens while it waits and stalls only when
// a second result is due before res_o takes the first.
//
// Reset (asynchronous, active low) clears the expression state, the
// sequencer and the output valid; no clearing pass is needed.
module infix_integer_expression_evaluator_core (
  input  logic clk_i,
  input  logic rst_ni,
  iiee_in_if.sink    in_tok_i,
  iiee_out_if.source res_o
);
  import iiee_pkg::*;

  pc_t   pc_q, pc_d;
  ucw_t  word;
  stat_t stat;
  logic  in_fire;
  logic  token_ok;
  logic  jump;

  iiee_ucode_rom u_rom (
    .pc_i   (pc_q),
    .word_o (word)
  );

  // Take a token only in the fetch step.
  assign in_tok_i.ready = (word.uop == UOP_FETCH);
  assign in_fire        = in_tok_i.valid && in_tok_i.ready;
  assign token_ok       = in_fire && (in_tok_i.func <= FUNC_EQUALS);

  iiee_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .uop_i       (word.uop),
    .in_fire_i   (in_fire),
    .operand_i   (in_tok_i.operand),
    .func_i      (in_tok_i.func),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .out_value_o (res_o.value),
    .out_dz_o    (res_o.div_by_zero),
    .stat_o      (stat)
  );

  // Evaluate the jump condition of the current control word.
  always_comb begin
    case (word.cond)
      COND_ALWAYS:      jump = 1'b1;
      COND_NO_TOKEN:    jump = !token_ok;
      COND_MOP_NONE:    jump = stat.mop_none;
      COND_MOP_TIMES:   jump = stat.mop_times;
      COND_DIV_ZERO:    jump = stat.x_zero;
      COND_DIV_MORE:    jump = stat.div_more;
      COND_FUNC_MUL:    jump = stat.func_mul;
      COND_FUNC_NOT_EQ: jump = stat.func_not_eq;
      COND_OUT_BUSY:    jump = stat.out_busy;
      default:          jump = 1'b1;
    endcase
  end

  // Jump on a true condition, otherwise advance or return to fetch.
  always_comb begin
    if (jump) begin
      pc_d = word.target;
    end else if (word.last) begin
      pc_d = PC_FETCH;
    end else begin
      pc_d = pc_q + pc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

`ifndef SYNTHESIS
  // A new result comes only from the emit step.
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !$past(res_o.valid)) |-> ($past(pc_q) == PC_EMIT))
    else $error("result raised outside the emit step");

  // A dropped token leaves the sequencer in fetch.
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !token_ok) |=> (pc_q == PC_FETCH))
    else $error("unknown operator did not drop the token");

  // The divide loop only repeats or finishes.
  a_div_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == PC_DIV_STEP) |=> ((pc_q == PC_DIV_STEP) || (pc_q == PC_DIV_FIN)))
    else $error("divide loop left early");

  // A pending result is never overwritten while the receiver stalls.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |=> (res_o.valid && $stable(res_o.value)))
    else $error("stalled result changed");
`endif

endmodule

// File: design/iiee_ucode_rom.sv
// Control store of the evaluator: one control word per program step.
module iiee_ucode_rom (
  input  iiee_pkg::pc_t  pc_i,
  output iiee_pkg::ucw_t word_o
);
  import iiee_pkg::*;

  always_comb begin
    case (pc_i)
      PC_FETCH:    word_o = '{UOP_FETCH,     COND_NO_TOKEN,    PC_FETCH,    1'b0};
      PC_SEL_NONE: word_o = '{UOP_NOP,       COND_MOP_NONE,    PC_TERM_X,   1'b0};
      PC_SEL_MUL:  word_o = '{UOP_NOP,       COND_MOP_TIMES,   PC_MUL_LL,   1'b0};
      PC_DIV_INIT: word_o = '{UOP_DIV_INIT,  COND_DIV_ZERO,    PC_DIV_ZERO, 1'b0};
      PC_DIV_STEP: word_o = '{UOP_DIV_STEP,  COND_DIV_MORE,    PC_DIV_STEP, 1'b0};
      PC_DIV_FIN:  word_o = '{UOP_DIV_FIN,   COND_ALWAYS,      PC_MULOP,    1'b0};
      PC_DIV_ZERO: word_o = '{UOP_TERM_ZERO, COND_ALWAYS,      PC_MULOP,    1'b0};
      PC_TERM_X:   word_o = '{UOP_TERM_X,    COND_ALWAYS,      PC_MULOP,    1'b0};
      PC_MUL_LL:   word_o = '{UOP_MUL_LL,    COND_ALWAYS,      PC_MUL_LH,   1'b0};
      PC_MUL_LH:   word_o = '{UOP_MUL_LH,    COND_ALWAYS,      PC_MUL_HL,   1'b0};
      PC_MUL_HL:   word_o = '{UOP_MUL_HL,    COND_ALWAYS,      PC_MUL_ACC,  1'b0};
      PC_MUL_ACC:  word_o = '{UOP_MUL_ACC,   COND_ALWAYS,      PC_MULOP,    1'b0};
      PC_MULOP:    word_o = '{UOP_MULOP,     COND_FUNC_MUL,    PC_FETCH,    1'b0};
      PC_ADD:      word_o = '{UOP_ADD,       COND_FUNC_NOT_EQ, PC_FETCH,    1'b0};
      PC_EMIT:     word_o = '{UOP_EMIT,      COND_OUT_BUSY,    PC_EMIT,     1'b1};
      default:     word_o = '{UOP_NOP,       COND_ALWAYS,      PC_FETCH,    1'b1};
    endcase
  end

endmodule

// File: design/iiee_datapath.sv
// Evaluator datapath: expression state, shared 32x32 multiplier, serial divider.
module iiee_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  iiee_pkg::uop_e        uop_i,
  input  logic                  in_fire_i,
  input  logic signed [63:0]    operand_i,
  input  logic        [2:0]     func_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic signed [63:0]    out_value_o,
  output logic                  out_dz_o,
  output iiee_pkg::stat_t       stat_o
);
  import iiee_pkg::*;

  // Expression state (reset) and result register.
  logic [63:0] sum_q, sum_d;
  logic [63:0] prod_q, prod_d;
  logic        sub_q, sub_d;
  logic [1:0]  mop_q, mop_d;
  logic        err_q, err_d;
  logic        ovld_q, ovld_d;
  logic [5:0]  cnt_q, cnt_d;

  // Working registers (no reset).
  logic [63:0] x_q, x_d;
  logic [2:0]  f_q, f_d;
  logic [63:0] term_q, term_d;
  logic [63:0] p_q, p_d;
  logic [63:0] dvd_q, dvd_d;
  logic [63:0] dvs_q, dvs_d;
  logic [63:0] rem_q, rem_d;
  logic        neg_q, neg_d;
  logic [63:0] oval_q, oval_d;
  logic        odz_q, odz_d;

  logic [31:0] ma, mb;
  logic [64:0] trial, diff;
  logic        emit_ok;

  assign emit_ok = !(ovld_q && !out_ready_i);
  assign trial   = {rem_q, dvd_q[63]};
  assign diff    = trial - {1'b0, dvs_q};

  always_comb begin
    case (uop_i)
      UOP_MUL_LH: begin ma = prod_q[31:0];  mb = x_q[63:32]; end
      UOP_MUL_HL: begin ma = prod_q[63:32]; mb = x_q[31:0];  end
      default:    begin ma = prod_q[31:0];  mb = x_q[31:0];  end
    endcase
  end

  always_comb begin
    sum_d  = sum_q;
    prod_d = prod_q;
    sub_d  = sub_q;
    mop_d  = mop_q;
    err_d  = err_q;
    ovld_d = ovld_q && !out_ready_i;
    cnt_d  = cnt_q;
    x_d    = x_q;
    f_d    = f_q;
    term_d = term_q;
    p_d    = p_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    oval_d = oval_q;
    odz_d  = odz_q;
    case (uop_i)
      UOP_FETCH: begin
        if (in_fire_i) begin
          x_d = operand_i;
          f_d = func_i;
        end
      end
      UOP_DIV_INIT: begin
        dvd_d = prod_q[63] ? (64'd0 - prod_q) : prod_q;
        dvs_d = x_q[63] ? (64'd0 - x_q) : x_q;
        neg_d = prod_q[63] ^ x_q[63];
        rem_d = '0;
        cnt_d = '0;
      end
      UOP_DIV_STEP: begin
        if (!diff[64]) begin
          rem_d = diff[63:0];
        end else begin
          rem_d = trial[63:0];
        end
        dvd_d = {dvd_q[62:0], !diff[64]};
        cnt_d = cnt_q + 6'd1;
      end
      UOP_DIV_FIN:   term_d = neg_q ? (64'd0 - dvd_q) : dvd_q;
      UOP_TERM_ZERO: begin
        term_d = '0;
        err_d  = 1'b1;
      end
      UOP_TERM_X:  term_d = x_q;
      UOP_MUL_LL:  p_d = 64'(ma) * 64'(mb);
      UOP_MUL_LH: begin
        term_d = p_q;
        p_d    = 64'(ma) * 64'(mb);
      end
      UOP_MUL_HL: begin
        term_d = term_q + {p_q[31:0], 32'd0};
        p_d    = 64'(ma) * 64'(mb);
      end
      UOP_MUL_ACC: term_d = term_q + {p_q[31:0], 32'd0};
      UOP_MULOP: begin
        prod_d = term_q;
        mop_d  = (f_q == FUNC_TIMES) ? MOP_TIMES : MOP_DIVIDE;
      end
      UOP_ADD: begin
        sum_d  = sub_q ? (sum_q - term_q) : (sum_q + term_q);
        prod_d = '0;
        mop_d  = MOP_NONE;
        sub_d  = (f_q == FUNC_MINUS);
      end
      UOP_EMIT: begin
        if (emit_ok) begin
          ovld_d = 1'b1;
          oval_d = sum_q;
          odz_d  = err_q;
          sum_d  = '0;
          prod_d = '0;
          sub_d  = 1'b0;
          mop_d  = MOP_NONE;
          err_d  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      prod_q <= '0;
      sub_q  <= 1'b0;
      mop_q  <= MOP_NONE;
      err_q  <= 1'b0;
      ovld_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      sum_q  <= sum_d;
      prod_q <= prod_d;
      sub_q  <= sub_d;
      mop_q  <= mop_d;
      err_q  <= err_d;
      ovld_q <= ovld_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    f_q    <= f_d;
    term_q <= term_d;
    p_q    <= p_d;
    dvd_q  <= dvd_d;
    dvs_q  <= dvs_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    oval_q <= oval_d;
    odz_q  <= odz_d;
  end

  assign out_valid_o = ovld_q;
  assign out_value_o = oval_q;
  assign out_dz_o    = odz_q;

  assign stat_o.mop_none    = (mop_q == MOP_NONE);
  assign stat_o.mop_times   = (mop_q == MOP_TIMES);
  assign stat_o.x_zero      = (x_q == 64'd0);
  assign stat_o.div_more    = (cnt_q != 6'd63);
  assign stat_o.func_mul    = (f_q == FUNC_TIMES) || (f_q == FUNC_DIVIDE);
  assign stat_o.func_not_eq = (f_q != FUNC_EQUALS);
  assign stat_o.out_busy    = !emit_ok;

endmodule
